>>> rtl/qcbp_pkg.sv
// ---------------------------------------------------------------------------
// qcbp_pkg
// Shared widths and constants of the quad clip-below-plane unit.
// ---------------------------------------------------------------------------
`default_nettype none

package qcbp_pkg;

    localparam int FIELD_W     = 32;
    localparam int IN_TDATA_W  = 320;
    localparam int OUT_TDATA_W = 168;
    localparam int TEX_W       = 17;
    localparam int EMIT_W      = 8;
    localparam int DIV_STEPS   = 17;

    localparam logic [TEX_W-1:0] ONE_Q16 = 17'h10000;

    // Corner i adds the half-width axis when R_POS[i], the half-height axis when U_POS[i]
    localparam logic [3:0] R_POS = 4'b1100;
    localparam logic [3:0] U_POS = 4'b1001;
    // Fixed texture coordinate of each corner (set = 1.0)
    localparam logic [3:0] CORNER_U = 4'b1100;
    localparam logic [3:0] CORNER_V = 4'b0110;

    // Bit 2i: corner i is kept; bit 2i+1: edge from corner i to corner i+1 crosses
    typedef logic [EMIT_W-1:0] emit_mask_t;

endpackage

`default_nettype wire

>>> rtl/quad_clip_below_plane_unit.sv
// ---------------------------------------------------------------------------
// quad_clip_below_plane_unit
// Clips one quad against a horizontal plane and streams its triangle fan.
// ---------------------------------------------------------------------------
// Each input transaction carries a quad (centre plus two half-axes, Q16.16)
// and a colour; the unit forms the four corners, keeps those at or above
// clip_height and inserts a crossing vertex on every edge that straddles the
// plane, then sends the fan one vertex per output transaction, tlast on the
// final one. Quads leaving two or fewer vertices produce no output. Timing:
// the front end classifies a quad in the cycle it is accepted and places it
// in a two-entry queue; the back end sends one kept corner per cycle while
// the output register is free, and a crossing vertex passes through edge
// selection, the bit-serial divider that forms the crossing factor, the
// shared multiplier and adder over x, y, z, and a final issue step.
// clip_height may only be written while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module quad_clip_below_plane_unit #(
    parameter int COORD_WIDTH = 32    // internal corner width, 16..48
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data,   // clip_height, signed Q16.16
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // center_x, center_y, center_z, right_x, right_y, right_z,
    // up_x, up_y, up_z, vertex_color (32 bits each, lowest first)
    input  wire logic [319:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], tex_u[112:96],
    // tex_v[129:113], out_color[161:130], zero pad
    output logic [167:0]      m_tdata,
    output logic              m_tlast          // last_vertex
);
    import qcbp_pkg::*;

    localparam int ENTRY_W = 12 * COORD_WIDTH + FIELD_W + EMIT_W;

    logic signed [FIELD_W-1:0] clip_height_reg;
    logic                      fifo_full;
    logic                      push;
    logic [ENTRY_W-1:0]        entry;
    logic                      pop;
    logic                      head_valid;
    logic [ENTRY_W-1:0]        head_data;

    // plane height register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_height_reg <= '0;
        end else if (cfg_wr_en) begin
            clip_height_reg <= $signed(cfg_wr_data);
        end
    end

    // front end: corners, inside test, emit mask
    qcbp_front #(.CW(COORD_WIDTH)) u_front (
        .clip_height (clip_height_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .fifo_full   (fifo_full),
        .push        (push),
        .entry       (entry)
    );

    // decoupling queue
    qcbp_fifo #(.WIDTH(ENTRY_W)) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (entry),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // back end: crossing interpolation and output register
    qcbp_back #(.CW(COORD_WIDTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clip_height (clip_height_reg),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/qcbp_fifo.sv
// ---------------------------------------------------------------------------
// qcbp_fifo
// Two-entry queue of classified quads between front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module qcbp_fifo #(
    parameter int WIDTH = 432
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop && head_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push && !full, pop && head_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/qcbp_front.sv
// ---------------------------------------------------------------------------
// qcbp_front
// Builds the four corners, tests them against the plane, marks emitted vertices.
// ---------------------------------------------------------------------------
`default_nettype none

module qcbp_front #(
    parameter int CW = 32
) (
    input  wire logic signed [qcbp_pkg::FIELD_W-1:0]    clip_height,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic        [qcbp_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                                   fifo_full,
    output logic                                        push,
    output logic [12*CW+qcbp_pkg::FIELD_W+qcbp_pkg::EMIT_W-1:0] entry
);
    import qcbp_pkg::*;

    localparam int SW = (CW > 34) ? CW : 34;
    localparam int XW = (CW > 32) ? CW : 32;

    logic       [CW-1:0] corner [4][3];
    logic       [3:0]    kept;
    emit_mask_t          emit;
    logic       [3:0]    n_vtx;

    always_comb begin
        logic signed [SW-1:0] cv, rv, uv, pv;
        logic signed [XW-1:0] yx, hx;
        for (int i = 0; i < 4; i++) begin
            for (int a = 0; a < 3; a++) begin
                cv = SW'($signed(s_tdata[a*FIELD_W +: FIELD_W]));
                rv = SW'($signed(s_tdata[(3+a)*FIELD_W +: FIELD_W]));
                uv = SW'($signed(s_tdata[(6+a)*FIELD_W +: FIELD_W]));
                pv = cv + (R_POS[i] ? rv : -rv) + (U_POS[i] ? uv : -uv);
                corner[i][a] = pv[CW-1:0];
            end
            yx = XW'($signed(corner[i][1]));
            hx = XW'(clip_height);
            kept[i] = (yx >= hx);
        end
        for (int i = 0; i < 4; i++) begin
            emit[2*i]   = kept[i];
            emit[2*i+1] = kept[i] ^ kept[(i+1) % 4];
        end
        n_vtx = 4'd0;
        for (int b = 0; b < EMIT_W; b++) begin
            n_vtx = n_vtx + {3'd0, emit[b]};
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int a = 0; a < 3; a++) begin
                entry[(i*3+a)*CW +: CW] = corner[i][a];
            end
        end
        entry[12*CW +: FIELD_W]          = s_tdata[9*FIELD_W +: FIELD_W];
        entry[12*CW+FIELD_W +: EMIT_W]   = emit;
    end

    // fans of two or fewer vertices are dropped here
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full && (n_vtx > 4'd2);

endmodule

`default_nettype wire

>>> rtl/qcbp_back.sv
// ---------------------------------------------------------------------------
// qcbp_back
// Walks the emit mask of each quad, interpolates crossings, drives the output.
// ---------------------------------------------------------------------------
`default_nettype none

module qcbp_back #(
    parameter int CW = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic signed [qcbp_pkg::FIELD_W-1:0]     clip_height,
    input  wire logic                                    head_valid,
    input  wire logic [12*CW+qcbp_pkg::FIELD_W+qcbp_pkg::EMIT_W-1:0] head_data,
    output logic                                         pop,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic             [qcbp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                         m_tlast
);
    import qcbp_pkg::*;

    localparam int XW = (CW > 32) ? CW : 32;
    localparam int DW = CW + 1;

    typedef enum logic [2:0] {ST_SEL, ST_DIV, ST_MUL, ST_ADD, ST_EMIT} state_t;

    state_t                   state_reg;
    logic                     loaded_reg;
    emit_mask_t               rem_mask_reg;
    logic [DW:0]              rem_reg;
    logic [DW-1:0]            den_reg;
    logic [TEX_W-1:0]         q_reg;
    logic [4:0]               cnt_reg;
    logic [1:0]               axis_reg;
    logic [CW+TEX_W:0]        prod_reg;
    logic                     neg_reg;
    logic [CW-1:0]            res_reg [3];
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic                     m_tlast_reg;

    logic [CW-1:0]     corner [4][3];
    logic [FIELD_W-1:0] color;
    emit_mask_t        cur_mask;
    logic [2:0]        p;
    logic              last;
    logic [1:0]        ci, cj;
    logic              out_free;
    logic              out_load;
    logic [DW-1:0]     num, den, magd;
    logic              dneg;
    logic [DW+1:0]     diff;
    logic [CW+1:0]     sum;

    function automatic logic [FIELD_W-1:0] to_out(input logic [CW-1:0] v);
        logic signed [XW-1:0] t;
        t = XW'($signed(v));
        return t[FIELD_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int a = 0; a < 3; a++) begin
                corner[i][a] = head_data[(i*3+a)*CW +: CW];
            end
        end
    end

    assign color    = head_data[12*CW +: FIELD_W];
    assign cur_mask = loaded_reg ? rem_mask_reg : head_data[12*CW+FIELD_W +: EMIT_W];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        p = 3'd0;
        for (int b = EMIT_W - 1; b >= 0; b--) begin
            if (cur_mask[b]) begin
                p = 3'(b);
            end
        end
    end

    assign last = ((cur_mask & ~(emit_mask_t'(1) << p)) == '0);
    assign ci   = p[2:1];
    assign cj   = ci + 2'd1;

    // a vertex enters the output register this cycle
    assign out_load = out_free &&
                      ((state_reg == ST_SEL && head_valid && !p[0]) || state_reg == ST_EMIT);

    // Crossing set-up: |clip - ya| and |yb - ya|
    always_comb begin
        logic signed [XW:0] nd;
        logic signed [CW:0] dd, da;
        nd   = (XW+1)'(clip_height) - (XW+1)'($signed(corner[ci][1]));
        num  = nd[XW] ? DW'(-nd) : DW'(nd);
        dd   = (CW+1)'($signed(corner[cj][1])) - (CW+1)'($signed(corner[ci][1]));
        den  = dd[CW] ? DW'(-dd) : DW'(dd);
        da   = (CW+1)'($signed(corner[cj][axis_reg])) -
               (CW+1)'($signed(corner[ci][axis_reg]));
        dneg = da[CW];
        magd = da[CW] ? DW'(-da) : DW'(da);
    end

    assign diff = {1'b0, rem_reg} - {2'b00, den_reg};

    always_comb begin
        logic [CW+1:0] off;
        off = (CW+2)'(prod_reg[CW+TEX_W-1:TEX_W-1]);
        sum = (CW+2)'($signed(corner[ci][axis_reg])) + (neg_reg ? -off : off);
    end

    assign pop = head_valid && last && out_free &&
                 ((state_reg == ST_SEL && !p[0]) || state_reg == ST_EMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SEL;
            loaded_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_SEL: begin
                    if (head_valid && !p[0] && out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= last;
                        m_tdata_reg  <= {6'd0, color,
                                         (CORNER_V[ci] ? ONE_Q16 : TEX_W'(0)),
                                         (CORNER_U[ci] ? ONE_Q16 : TEX_W'(0)),
                                         to_out(corner[ci][2]), to_out(corner[ci][1]),
                                         to_out(corner[ci][0])};
                        loaded_reg   <= !last;
                        rem_mask_reg <= cur_mask & ~(emit_mask_t'(1) << p);
                    end else if (head_valid && p[0]) begin
                        rem_reg      <= {1'b0, num};
                        den_reg      <= den;
                        q_reg        <= '0;
                        cnt_reg      <= 5'(DIV_STEPS - 1);
                        loaded_reg   <= 1'b1;
                        rem_mask_reg <= cur_mask;
                        state_reg    <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    q_reg   <= {q_reg[TEX_W-2:0], !diff[DW+1]};
                    rem_reg <= diff[DW+1] ? {rem_reg[DW-1:0], 1'b0}
                                          : {diff[DW-1:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        axis_reg  <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= (CW+TEX_W+1)'(magd * q_reg);
                    neg_reg   <= dneg;
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    res_reg[axis_reg] <= sum[CW-1:0];
                    if (axis_reg == 2'd2) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        logic [TEX_W-1:0] tu, tv;
                        case (ci)
                            2'd0:    begin tu = '0;               tv = q_reg;           end
                            2'd1:    begin tu = q_reg;            tv = ONE_Q16;         end
                            2'd2:    begin tu = ONE_Q16;          tv = ONE_Q16 - q_reg; end
                            default: begin tu = ONE_Q16 - q_reg;  tv = '0;              end
                        endcase
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= last;
                        m_tdata_reg  <= {6'd0, color, tv, tu, to_out(res_reg[2]),
                                         to_out(res_reg[1]), to_out(res_reg[0])};
                        loaded_reg   <= !last;
                        rem_mask_reg <= cur_mask & ~(emit_mask_t'(1) << p);
                        state_reg    <= ST_SEL;
                    end
                end
                default: state_reg <= ST_SEL;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop with empty queue");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> ({1'b0, rem_reg} < {den_reg, 1'b0}))
        else $error("division remainder out of range");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> (q_reg <= ONE_Q16))
        else $error("crossing factor above one");

endmodule

`default_nettype wire
